// ===== sv/cwm_pkg.sv =====
// Shared types, constants and elaboration-time table builders for the Web Mercator projector.
// No dependencies; every other file refers to this package by scoped names.
package cwm_pkg;

  localparam int EARTH_RADIUS_M_DEF = 6378137;

  localparam int FRAC       = 56;
  localparam int CIRC_CELLS = 56;
  localparam int HYP_CELLS  = 59;
  localparam int LATENCY    = 2 + CIRC_CELLS + 3 + HYP_CELLS + 3;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] LAT_K  = ((PI_Q60 / 64'd3600000000) << 20) +
                                   (((PI_Q60 % 64'd3600000000) << 20) / 64'd3600000000);
  localparam logic [63:0] LON_K  = ((PI_Q60 / 64'd1800000) << 20) +
                                   (((PI_Q60 % 64'd1800000) << 20) / 64'd1800000);
  localparam logic [63:0] PI_Q   = (PI_Q60 + 64'd8) >> 4;
  localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC;

  // Side data that rides along with the CORDIC vector through every cell.
  typedef struct packed {
    logic        lat_neg;
    logic        sat;
    logic [2:0]  n;
    logic [35:0] east;
    logic [31:0] height;
  } side_t;

  // (a*b + 2^61) >> 62, kept to 64 bits.
  function automatic logic [63:0] mshr62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b} + (128'd1 << 61);
    return p[125:62];
  endfunction

  // Odd power series of a Q62 argument: arctan when alt is set, else artanh; Q56 result.
  function automatic logic [63:0] odd_series(input logic [63:0] x, input logic alt);
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] t;
    x2  = mshr62(x, x);
    p   = x;
    sum = 64'd0;
    for (int k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        t = p / 64'(2 * k + 1);
        if (alt && k[0]) sum = sum - t;
        else sum = sum + t;
        p = mshr62(p, x2);
      end
    end
    return (sum + 64'd32) >> 6;
  endfunction

  function automatic logic signed [63:0] atan_q(input int i);
    if (i == 0) return signed'((PI_Q60 + 64'd32) >> 6);
    return signed'(odd_series(64'd1 << (62 - i), 1'b1));
  endfunction

  function automatic logic signed [63:0] atanh_q(input int i);
    return signed'(odd_series(64'd1 << (62 - i), 1'b0));
  endfunction

  // Shift amount of hyperbolic cell j; steps 4, 13 and 40 appear twice.
  function automatic int hyp_shift(input int j);
    int s;
    s = j + 1;
    if (j >= 4) s = s - 1;
    if (j >= 14) s = s - 1;
    if (j >= 42) s = s - 1;
    return s;
  endfunction

  localparam logic [63:0] LN2_Q = odd_series((64'd1 << 62) / 64'd3, 1'b0) << 1;

  function automatic logic signed [63:0] ln2_mult(input logic [2:0] n);
    return signed'(64'(n) * LN2_Q);
  endfunction

  // Radius times the longitude scale, for a 1e-7 degree to millimetre product.
  function automatic logic [127:0] lon_scale(input int r);
    return 128'(r) * {64'd0, LON_K};
  endfunction

  function automatic logic [32:0] radius_mm(input int r);
    return 33'(64'(r) * 64'd1000);
  endfunction

  // Map bound round(pi * R) in millimetres.
  function automatic logic [35:0] bound_mm(input int r);
    logic [127:0] p;
    p = {64'd0, PI_Q60} * 128'(radius_mm(r)) + (128'd1 << 59);
    return p[95:60];
  endfunction

endpackage

// ===== sv/cwm_front.sv =====
// Input scaling: longitude to easting and half latitude to a Q56 angle, two stages.
// Depends on cwm_pkg.
module cwm_front #(
  parameter int EARTH_RADIUS_M = cwm_pkg::EARTH_RADIUS_M_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic signed [31:0]  in_lon,
  input  logic signed [30:0]  in_lat,
  input  logic signed [31:0]  in_hgt,
  output logic                out_vld,
  output logic signed [63:0]  out_z,
  output cwm_pkg::side_t      out_side
);

  localparam logic [127:0] LON_KR = cwm_pkg::lon_scale(EARTH_RADIUS_M);

  logic        lon_neg, lat_neg;
  logic [31:0] lon_mag;
  logic [30:0] lat_mag;

  logic        v1_r, v1_nxt;
  logic        lon_neg_r, lat_neg_r;
  logic [31:0] hgt_r;
  logic [63:0] q0_r, q1_r, q2_r;
  logic [62:0] lp0_r, lp1_r;

  logic [95:0]  zsum;
  logic [127:0] esum;
  logic [35:0]  emag;

  logic                v2_r, v2_nxt;
  logic signed [63:0]  z_r;
  cwm_pkg::side_t      side_r, side_nxt;

  assign lon_neg = in_lon[31];
  assign lat_neg = in_lat[30];
  assign lon_mag = lon_neg ? 32'(-$unsigned(in_lon)) : $unsigned(in_lon);
  assign lat_mag = lat_neg ? 31'(-$unsigned(in_lat)) : $unsigned(in_lat);
  assign v1_nxt  = in_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lon_neg_r <= lon_neg;
    lat_neg_r <= lat_neg;
    hgt_r     <= in_hgt;
    q0_r      <= {32'd0, lon_mag} * {32'd0, LON_KR[31:0]};
    q1_r      <= {32'd0, lon_mag} * {32'd0, LON_KR[63:32]};
    q2_r      <= {32'd0, lon_mag} * {32'd0, LON_KR[95:64]};
    lp0_r     <= {32'd0, lat_mag} * {31'd0, cwm_pkg::LAT_K[31:0]};
    lp1_r     <= {32'd0, lat_mag} * {32'd0, cwm_pkg::LAT_K[62:32]};
  end

  always_comb begin
    zsum = 96'(lp0_r) + (96'(lp1_r) << 32) + (96'd1 << 23);
    esum = 128'(q0_r) + (128'(q1_r) << 32) + (128'(q2_r) << 64) + (128'd1 << 79);
    emag = esum[115:80];
    side_nxt.lat_neg = lat_neg_r;
    side_nxt.sat     = 1'b0;
    side_nxt.n       = 3'd0;
    side_nxt.east    = lon_neg_r ? 36'(-emag) : emag;
    side_nxt.height  = hgt_r;
  end

  assign v2_nxt = v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    z_r    <= signed'(zsum[87:24]);
    side_r <= side_nxt;
  end

  assign out_vld  = v2_r;
  assign out_z    = z_r;
  assign out_side = side_r;

endmodule

// ===== sv/cwm_cell.sv =====
// One CORDIC micro-rotation cell, circular rotation or hyperbolic vectoring.
// Depends on cwm_pkg for the side data type.
module cwm_cell #(
  parameter bit                 HYP   = 1'b0,
  parameter int                 SHIFT = 0,
  parameter logic signed [63:0] ANGLE = 64'sd0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [63:0] in_x,
  input  logic signed [63:0] in_y,
  input  logic signed [63:0] in_z,
  input  cwm_pkg::side_t     in_side,
  output logic               out_vld,
  output logic signed [63:0] out_x,
  output logic signed [63:0] out_y,
  output logic signed [63:0] out_z,
  output cwm_pkg::side_t     out_side
);

  logic               pos, ysub, zsub;
  logic signed [63:0] dx, dy;
  logic               vld_r;
  logic signed [63:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  cwm_pkg::side_t     side_r;

  // Rotation steers on the residual angle, vectoring on the sign of y.
  always_comb begin
    dx    = in_y >>> SHIFT;
    dy    = in_x >>> SHIFT;
    pos   = HYP ? !in_y[63] : !in_z[63];
    ysub  = HYP ? pos : !pos;
    zsub  = HYP ? !pos : pos;
    x_nxt = pos ? in_x - dx : in_x + dx;
    y_nxt = ysub ? in_y - dy : in_y + dy;
    z_nxt = zsub ? in_z - ANGLE : in_z + ANGLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    side_r <= in_side;
  end

  assign out_vld  = vld_r;
  assign out_x    = x_r;
  assign out_y    = y_r;
  assign out_z    = z_r;
  assign out_side = side_r;

endmodule

// ===== sv/cwm_bridge.sv =====
// Forms the ratio (cos+sin)/(cos-sin), checks the pole range and prescales by 2^n.
// Three stages between the two cell chains; depends on cwm_pkg.
module cwm_bridge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [63:0] in_x,
  input  logic signed [63:0] in_y,
  input  cwm_pkg::side_t     in_side,
  output logic               out_vld,
  output logic signed [63:0] out_x,
  output logic signed [63:0] out_y,
  output cwm_pkg::side_t     out_side
);

  logic               va_r, vb_r, vc_r;
  logic signed [63:0] a_r, b_r, a2_r, bsh_r, xx_r, yy_r;
  cwm_pkg::side_t     sa_r, sb_r, sc_r, sb_nxt;
  logic [63:0]        au, bu, bsh_nxt;
  logic               c1, c2, c3, c4, c5;
  logic [2:0]         n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= in_vld;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  // The prescale n is the largest value up to four with b*2^n still not above a.
  always_comb begin
    au = $unsigned(a_r);
    bu = $unsigned(b_r);
    c1 = (bu << 1) <= au;
    c2 = (bu << 2) <= au;
    c3 = (bu << 3) <= au;
    c4 = (bu << 4) <= au;
    c5 = (bu << 5) <= au;
    n  = c1 ? (c2 ? (c3 ? (c4 ? 3'd4 : 3'd3) : 3'd2) : 3'd1) : 3'd0;
    bsh_nxt    = bu << n;
    sb_nxt     = sa_r;
    sb_nxt.sat = (b_r <= 64'sd0) || c5;
    sb_nxt.n   = n;
  end

  always_ff @(posedge clk) begin
    a_r   <= in_x + in_y;
    b_r   <= in_x - in_y;
    sa_r  <= in_side;
    a2_r  <= a_r;
    bsh_r <= signed'(bsh_nxt);
    sb_r  <= sb_nxt;
    xx_r  <= a2_r + bsh_r;
    yy_r  <= a2_r - bsh_r;
    sc_r  <= sb_r;
  end

  assign out_vld  = vc_r;
  assign out_x    = xx_r;
  assign out_y    = yy_r;
  assign out_side = sc_r;

endmodule

// ===== sv/cwm_tail.sv =====
// Turns the hyperbolic angle into the logarithm, scales it to millimetres and clamps.
// Three stages; depends on cwm_pkg.
module cwm_tail #(
  parameter int EARTH_RADIUS_M = cwm_pkg::EARTH_RADIUS_M_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [63:0] in_z,
  input  cwm_pkg::side_t     in_side,
  output logic               out_vld,
  output logic [35:0]        out_east,
  output logic [35:0]        out_north,
  output logic [31:0]        out_height,
  output logic               out_sat
);

  localparam logic [32:0] RMM   = cwm_pkg::radius_mm(EARTH_RADIUS_M);
  localparam logic [35:0] BOUND = cwm_pkg::bound_mm(EARTH_RADIUS_M);

  logic               vl_r, vm_r, vo_r;
  logic signed [63:0] lg;
  logic [57:0]        lg_r;
  cwm_pkg::side_t     sl_r, sm_r, sl_nxt;
  logic [64:0]        p0_r;
  logic [58:0]        p1_r;
  logic [95:0]        nsum;
  logic [35:0]        nmag;
  logic [35:0]        east_r, north_r;
  logic [31:0]        hgt_r;
  logic               sat_r;

  always_comb begin
    lg = cwm_pkg::ln2_mult(in_side.n) + (in_z <<< 1);
    if (lg < 64'sd0) lg = 64'sd0;
    sl_nxt     = in_side;
    sl_nxt.sat = in_side.sat || ($unsigned(lg) >= cwm_pkg::PI_Q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r <= 1'b0;
      vm_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      vl_r <= in_vld;
      vm_r <= vl_r;
      vo_r <= vm_r;
    end
  end

  always_comb begin
    nsum = 96'(p0_r) + (96'(p1_r) << 32) + (96'd1 << 55);
    nmag = sm_r.sat ? BOUND : nsum[91:56];
  end

  always_ff @(posedge clk) begin
    lg_r    <= lg[57:0];
    sl_r    <= sl_nxt;
    p0_r    <= {33'd0, lg_r[31:0]} * {32'd0, RMM};
    p1_r    <= {33'd0, lg_r[57:32]} * {26'd0, RMM};
    sm_r    <= sl_r;
    east_r  <= sm_r.east;
    north_r <= sm_r.lat_neg ? 36'(-nmag) : nmag;
    hgt_r   <= sm_r.height;
    sat_r   <= sm_r.sat;
  end

  assign out_vld    = vo_r;
  assign out_east   = east_r;
  assign out_north  = north_r;
  assign out_height = hgt_r;
  assign out_sat    = sat_r;

endmodule

// ===== sv/wgs84_to_web_mercator.sv =====
// Top level of the WGS84 to spherical Web Mercator forward projector.
// Depends on cwm_pkg, cwm_front, cwm_cell, cwm_bridge and cwm_tail.
//
//   channel | handshake       | beat contents
//   --------+-----------------+--------------------------------------------
//   input   | start, busy     | in_longitude, in_latitude, in_height
//   result  | out_valid       | out_east_mm, out_north_mm, out_height_out,
//           |                 | out_saturated
//
// One beat is accepted every cycle; busy is never raised.
// Each input beat passes through two scaling stages, 56 circular
// CORDIC cells, three ratio stages, 59 hyperbolic CORDIC cells and three output stages.
// Reset (synchronous, rst_n low) clears every valid bit and drops beats in flight.
// The receiver cannot stall, so the chain never holds.
module wgs84_to_web_mercator #(
  parameter int EARTH_RADIUS_M = cwm_pkg::EARTH_RADIUS_M_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_longitude,
  input  logic signed [30:0] in_latitude,
  input  logic signed [31:0] in_height,
  output logic               out_valid,
  output logic signed [35:0] out_east_mm,
  output logic signed [35:0] out_north_mm,
  output logic signed [31:0] out_height_out,
  output logic               out_saturated
);

  localparam logic signed [35:0] BOUND_S = signed'(cwm_pkg::bound_mm(EARTH_RADIUS_M));

  logic acc;

  logic               cv [cwm_pkg::CIRC_CELLS+1];
  logic signed [63:0] cx [cwm_pkg::CIRC_CELLS+1];
  logic signed [63:0] cy [cwm_pkg::CIRC_CELLS+1];
  logic signed [63:0] cz [cwm_pkg::CIRC_CELLS+1];
  cwm_pkg::side_t     cs [cwm_pkg::CIRC_CELLS+1];

  logic               hv [cwm_pkg::HYP_CELLS+1];
  logic signed [63:0] hx [cwm_pkg::HYP_CELLS+1];
  logic signed [63:0] hy [cwm_pkg::HYP_CELLS+1];
  logic signed [63:0] hz [cwm_pkg::HYP_CELLS+1];
  cwm_pkg::side_t     hs [cwm_pkg::HYP_CELLS+1];

  logic [35:0] east_u, north_u;
  logic [31:0] hgt_u;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  cwm_front #(.EARTH_RADIUS_M(EARTH_RADIUS_M)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (acc),
    .in_lon   (in_longitude),
    .in_lat   (in_latitude),
    .in_hgt   (in_height),
    .out_vld  (cv[0]),
    .out_z    (cz[0]),
    .out_side (cs[0])
  );

  // The rotation starts from the unit vector on the x axis.
  assign cx[0] = cwm_pkg::ONE_Q;
  assign cy[0] = 64'sd0;

  for (genvar g = 0; g < cwm_pkg::CIRC_CELLS; g++) begin : g_circ
    cwm_cell #(
      .HYP   (1'b0),
      .SHIFT (g),
      .ANGLE (cwm_pkg::atan_q(g))
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (cv[g]),
      .in_x     (cx[g]),
      .in_y     (cy[g]),
      .in_z     (cz[g]),
      .in_side  (cs[g]),
      .out_vld  (cv[g+1]),
      .out_x    (cx[g+1]),
      .out_y    (cy[g+1]),
      .out_z    (cz[g+1]),
      .out_side (cs[g+1])
    );
  end

  cwm_bridge u_bridge (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (cv[cwm_pkg::CIRC_CELLS]),
    .in_x     (cx[cwm_pkg::CIRC_CELLS]),
    .in_y     (cy[cwm_pkg::CIRC_CELLS]),
    .in_side  (cs[cwm_pkg::CIRC_CELLS]),
    .out_vld  (hv[0]),
    .out_x    (hx[0]),
    .out_y    (hy[0]),
    .out_side (hs[0])
  );

  assign hz[0] = 64'sd0;

  for (genvar g = 0; g < cwm_pkg::HYP_CELLS; g++) begin : g_hyp
    cwm_cell #(
      .HYP   (1'b1),
      .SHIFT (cwm_pkg::hyp_shift(g)),
      .ANGLE (cwm_pkg::atanh_q(cwm_pkg::hyp_shift(g)))
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (hv[g]),
      .in_x     (hx[g]),
      .in_y     (hy[g]),
      .in_z     (hz[g]),
      .in_side  (hs[g]),
      .out_vld  (hv[g+1]),
      .out_x    (hx[g+1]),
      .out_y    (hy[g+1]),
      .out_z    (hz[g+1]),
      .out_side (hs[g+1])
    );
  end

  cwm_tail #(.EARTH_RADIUS_M(EARTH_RADIUS_M)) u_tail (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (hv[cwm_pkg::HYP_CELLS]),
    .in_z       (hz[cwm_pkg::HYP_CELLS]),
    .in_side    (hs[cwm_pkg::HYP_CELLS]),
    .out_vld    (out_valid),
    .out_east   (east_u),
    .out_north  (north_u),
    .out_height (hgt_u),
    .out_sat    (out_saturated)
  );

  assign out_east_mm    = signed'(east_u);
  assign out_north_mm   = signed'(north_u);
  assign out_height_out = signed'(hgt_u);

  // A result only comes out of a beat taken exactly one pipeline latency earlier.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, cwm_pkg::LATENCY))
    else $error("result without a matching input beat");

  a_height : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_height_out == $past(in_height, cwm_pkg::LATENCY))
    else $error("height lost its alignment in the chain");

  a_clamp : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> (out_north_mm == BOUND_S || out_north_mm == -BOUND_S))
    else $error("clamped northing is not on the map bound");

endmodule

// ===== test/wgs84_to_web_mercator_tb.sv =====
// Self-checking bench for the WGS84 to Web Mercator projector: directed and random positions.
// Depends on cwm_pkg and wgs84_to_web_mercator; the bench predicts every result on its own.
module wgs84_to_web_mercator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RADIUS = cwm_pkg::EARTH_RADIUS_M_DEF;
  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    logic [35:0] east;
    logic [35:0] north;
    logic [31:0] height;
    logic        sat;
  } proj_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] in_longitude = '0;
  logic signed [30:0] in_latitude = '0;
  logic signed [31:0] in_height = '0;
  logic               out_valid;
  logic signed [35:0] out_east_mm;
  logic signed [35:0] out_north_mm;
  logic signed [31:0] out_height_out;
  logic               out_saturated;

  proj_t       pending_q[$];
  int          n_errors = 0;
  int          n_sent = 0;
  int          n_results = 0;
  int          n_clamped = 0;
  int          quiet_cycles = 0;
  logic signed [63:0] arctan_q[56];
  logic signed [63:0] artanh_q[57];
  logic signed [63:0] ln2_val;
  logic [63:0] lat_scale;
  logic [63:0] lon_scale_k;

  wgs84_to_web_mercator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_longitude(in_longitude), .in_latitude(in_latitude), .in_height(in_height),
    .out_valid(out_valid), .out_east_mm(out_east_mm), .out_north_mm(out_north_mm),
    .out_height_out(out_height_out), .out_saturated(out_saturated)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Exact product, rounded half up, then shifted down by s.
  function automatic logic [63:0] round_shift(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b} + (128'd1 << (s - 1));
    return 64'(p >> s);
  endfunction

  function automatic logic signed [63:0] series_q56(logic [63:0] x, bit alt);
    logic [63:0] x2, p, sum, t;
    int k;
    x2 = round_shift(x, x, 62);
    p = x;
    sum = 0;
    k = 0;
    while (p != 0 && k < 64) begin
      t = p / 64'(2 * k + 1);
      if (alt && k[0]) sum = sum - t;
      else sum = sum + t;
      p = round_shift(p, x2, 62);
      k++;
    end
    return signed'((sum + 64'd32) >> 6);
  endfunction

  task automatic build_angle_tables();
    logic [63:0] pi60;
    pi60 = cwm_pkg::PI_Q60;
    arctan_q[0] = signed'((pi60 + 64'd32) >> 6);
    for (int i = 1; i < 56; i++) arctan_q[i] = series_q56(64'd1 << (62 - i), 1'b1);
    artanh_q[0] = 0;
    for (int i = 1; i <= 56; i++) artanh_q[i] = series_q56(64'd1 << (62 - i), 1'b0);
    ln2_val = 2 * series_q56((64'd1 << 62) / 64'd3, 1'b0);
    lat_scale = ((pi60 / 64'd3600000000) << 20) +
                (((pi60 % 64'd3600000000) << 20) / 64'd3600000000);
    lon_scale_k = ((pi60 / 64'd1800000) << 20) + (((pi60 % 64'd1800000) << 20) / 64'd1800000);
  endtask

  function automatic proj_t project(logic [31:0] lon, logic [30:0] lat, logic [31:0] hgt);
    proj_t r;
    logic [63:0] lon_mag, lat_mag, rmm, east, north, bound;
    logic [127:0] p;
    logic signed [63:0] x, y, z, a, b, xx, yy, zz, dx, dy, lg;
    bit sat;
    int n, reps;
    rmm = 64'(RADIUS) * 64'd1000;
    lon_mag = lon[31] ? 64'h100000000 - {32'd0, lon} : {32'd0, lon};
    p = {64'd0, lon_mag * 64'(RADIUS)} * {64'd0, lon_scale_k} + (128'd1 << 79);
    east = 64'(p >> 80);
    lat_mag = lat[30] ? 64'h80000000 - {33'd0, lat} : {33'd0, lat};
    // Rotate (1,0) by half the latitude.
    x = 64'sd1 <<< 56;
    y = 0;
    z = signed'(round_shift(lat_mag, lat_scale, 24));
    for (int i = 0; i < 56; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q[i];
      end else begin
        x += dx; y -= dy; z += arctan_q[i];
      end
    end
    a = x + y;
    b = x - y;
    sat = 0;
    lg = 0;
    if (b <= 0 || ($unsigned(b) << 5) <= $unsigned(a)) begin
      sat = 1;
    end else begin
      n = 0;
      while (n < 4 && ($unsigned(b) << (n + 1)) <= $unsigned(a)) n++;
      b = b << n;
      xx = a + b;
      yy = a - b;
      zz = 0;
      for (int i = 1; i <= 56; i++) begin
        reps = (i == 4 || i == 13 || i == 40) ? 2 : 1;
        for (int k = 0; k < reps; k++) begin
          dx = yy >>> i;
          dy = xx >>> i;
          if (yy >= 0) begin
            xx -= dx; yy -= dy; zz += artanh_q[i];
          end else begin
            xx += dx; yy += dy; zz -= artanh_q[i];
          end
        end
      end
      lg = 64'(n) * ln2_val + 2 * zz;
      if (lg < 0) lg = 0;
      if (lg >= signed'(cwm_pkg::PI_Q)) sat = 1;
    end
    bound = round_shift(cwm_pkg::PI_Q60, rmm, 60);
    north = sat ? bound : round_shift(lg, rmm, 56);
    r.east = 36'(lon[31] ? -east : east);
    r.north = 36'(lat[30] ? -north : north);
    r.height = hgt;
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s at %0t: got %0h, want %0h", what, $time, got, want);
    n_errors++;
  endtask

  // One beat: held until accepted; start stays high for a following beat.
  task automatic send_position(logic [31:0] lon, logic [30:0] lat, logic [31:0] hgt);
    @(negedge clk);
    start <= 1'b1;
    in_longitude <= lon;
    in_latitude <= lat;
    in_height <= hgt;
    do @(posedge clk); while (busy);
    pending_q.push_back(project(lon, lat, hgt));
    n_sent++;
  endtask

  task automatic idle_burst();
    int gap;
    gap = $urandom_range(19, 1);
    @(negedge clk);
    start <= 1'b0;
    repeat (gap - 1) @(negedge clk);
  endtask

  always @(posedge clk) begin
    proj_t e;
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_east_mm), 0);
      end else begin
        e = pending_q.pop_front();
        if (out_saturated) n_clamped++;
        if (out_east_mm !== e.east) report_mismatch("east_mm", 64'(out_east_mm), 64'(e.east));
        if (out_north_mm !== e.north)
          report_mismatch("north_mm", 64'(out_north_mm), 64'(e.north));
        if (out_height_out !== e.height)
          report_mismatch("height_out", 64'(out_height_out), 64'(e.height));
        if (out_saturated !== e.sat)
          report_mismatch("saturated", 64'(out_saturated), 64'(e.sat));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles", IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [30:0] random_latitude();
    int sel;
    int off;
    sel = $urandom_range(99);
    off = $urandom_range(5000000);
    if (sel < 65) return 31'($urandom_range(1800000000) - 900000000);
    // Band around the clamp point near 85.05 degrees, both hemispheres.
    if (sel < 80) return 31'(($urandom_range(1) ? 1 : -1) * (845000000 + $urandom_range(10000000)));
    if (sel < 88) return 31'(($urandom_range(1) ? 1 : -1) * (900000000 - off));
    if (sel < 93) return 31'($urandom_range(2000) - 1000);
    return 31'($urandom);
  endfunction

  function automatic logic [31:0] random_longitude();
    if ($urandom_range(9) < 8) return 32'($urandom_range(3600000000) - 1800000000);
    return $urandom;
  endfunction

  task automatic test_directed();
    logic [31:0] lons[8] = '{0, 1800000000, -1800000000, 32'h7fffffff, 32'h80000000,
                             1, -1, 1234567890};
    logic [30:0] lats[14] = '{0, 1, -1, 900000000, -900000000, 31'h3fffffff, 31'h40000000,
                              -31'sd1073741823, 850511287, -850511287, 850511300,
                              -850511300, 450000000, -10};
    for (int i = 0; i < 14; i++)
      send_position(lons[i % 8], lats[i], (i % 2) ? 32'h80000000 : 32'h7fffffff);
    send_position(0, 0, 0);
    send_position(32'hffffffff, 0, 32'hffffffff);
  endtask

  task automatic test_random_with_gaps(int count);
    for (int i = 0; i < count; i++) begin
      send_position(random_longitude(), random_latitude(), $urandom);
      if ($urandom_range(3) == 0) idle_burst();
    end
  endtask

  task automatic test_back_to_back(int count);
    for (int i = 0; i < count; i++) send_position(random_longitude(), random_latitude(), $urandom);
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    while (pending_q.size() != 0 && waited < 10 * cwm_pkg::LATENCY) begin
      @(posedge clk);
      waited++;
    end
    repeat (cwm_pkg::LATENCY + 10) @(posedge clk);
  endtask

  initial begin
    build_angle_tables();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_with_gaps(850);
    test_back_to_back(300);
    drain();
    $display("sent %0d positions, checked %0d results, %0d with a clamped northing",
             n_sent, n_results, n_clamped);
    if (n_errors == 0 && pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, pending_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
